@@ sv/cspd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cspd_pkg;

    localparam int DEF_HEADER_BYTES    = 20;
    localparam int DEF_DIM_LIMIT       = 4096;
    localparam int DEF_TELEMETRY_LIMIT = 16 * 1024;

    localparam int RAW_HDR_LEN = 20;
    localparam int TM_HDR_LEN  = 8;
    localparam int DIM_CMP_W   = 14;
    localparam int TM_CMP_W    = 17;
    localparam int CFG_W       = 32;

    localparam logic [31:0] MAX_RAW_PAYLOAD = 32'h0400_0000;

    localparam logic [1:0] CFG_MAX_DIM = 2'd0;
    localparam logic [1:0] CFG_MAX_TM  = 2'd1;
    localparam logic [1:0] CFG_PIX_FMT = 2'd2;

    localparam logic [12:0] RST_MAX_DIM = 13'd4096;
    localparam logic [14:0] RST_MAX_TM  = 15'd16384;
    localparam logic [31:0] RST_PIX_FMT = 32'd1;

    localparam logic [1:0] KIND_JPEG = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_TM   = 2'd2;

    localparam logic [7:0] CH_W   = 8'h57;
    localparam logic [7:0] CH_B   = 8'h42;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_R   = 8'h52;
    localparam logic [7:0] CH_T   = 8'h54;
    localparam logic [7:0] CH_M   = 8'h4D;
    localparam logic [7:0] JPEG_FF  = 8'hFF;
    localparam logic [7:0] JPEG_SOI = 8'hD8;
    localparam logic [7:0] JPEG_EOI = 8'hD9;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_RAW_HDR = 3'd1,
        PH_TM_HDR  = 3'd2,
        PH_RAW_PAY = 3'd3,
        PH_TM_PAY  = 3'd4,
        PH_JPEG    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        HP_NONE = 3'd0,
        HP_W    = 3'd1,
        HP_WB   = 3'd2,
        HP_WBF  = 3'd3,
        HP_WBT  = 3'd4,
        HP_FF   = 3'd5
    } t_hunt;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_FETCH = 3'd1,
        ST_PROC  = 3'd2,
        ST_JPG2  = 3'd3,
        ST_FLUSH = 3'd4
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        packet_start;
        logic        packet_end;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } t_result;

    typedef struct packed {
        logic take_in;
        logic take_mem;
        logic emit_d8;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic can_push;
        logic jpeg_start;
        logic more;
        logic flush_need;
    } t_status;

endpackage
`default_nettype wire

@@ sv/cspd_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cspd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

@@ sv/cspd_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cspd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        packet_start;
    logic        packet_end;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        run_last;

    modport source (output valid, output kind, output data_byte, output byte_valid,
                    output packet_start, output packet_end, output frame_width,
                    output frame_height, output run_last, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_valid,
                    input packet_start, input packet_end, input frame_width,
                    input frame_height, input run_last, output ready);
endinterface
`default_nettype wire

@@ sv/cspd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cspd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cspd_pkg::t_status i_status,
    output cspd_pkg::t_cmd    o_cmd
);
    import cspd_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state w_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        if (i_status.jpeg_start) begin
            w_after = ST_JPG2;
        end else if (i_status.more) begin
            w_after = ST_FETCH;
        end else if (i_status.flush_need) begin
            w_after = ST_FLUSH;
        end else begin
            w_after = ST_IDLE;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.can_push) n_state = w_after;
            end
            ST_FETCH: begin
                n_state = ST_PROC;
            end
            ST_PROC: begin
                if (i_status.can_push) n_state = w_after;
            end
            ST_JPG2: begin
                if (i_status.can_push) n_state = w_after;
            end
            ST_FLUSH: begin
                if (i_status.can_push) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = i_status.can_push;
                o_cmd.take_in = i_in_valid && i_status.can_push;
            end
            ST_PROC: begin
                o_cmd.take_mem = i_status.can_push;
            end
            ST_JPG2: begin
                o_cmd.emit_d8 = i_status.can_push;
            end
            ST_FLUSH: begin
                o_cmd.flush = i_status.can_push;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/cspd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cspd_datapath #(
    parameter int HEADER_BYTES    = cspd_pkg::DEF_HEADER_BYTES,
    parameter int DIM_LIMIT       = cspd_pkg::DEF_DIM_LIMIT,
    parameter int TELEMETRY_LIMIT = cspd_pkg::DEF_TELEMETRY_LIMIT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [cspd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [7:0]                   i_in_byte,
    input  cspd_pkg::t_cmd               i_cmd,
    output cspd_pkg::t_status            o_status,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output cspd_pkg::t_result            o_out_res,
    output logic                         o_out_last
);
    import cspd_pkg::*;

    localparam int AW    = $clog2(HEADER_BYTES) + 1;
    localparam int DEPTH = 1 << AW;
    localparam logic [DIM_CMP_W-1:0] DIM_LIM_C = DIM_CMP_W'(DIM_LIMIT);
    localparam logic [TM_CMP_W-1:0]  TM_LIM_C  = TM_CMP_W'(TELEMETRY_LIMIT);

    // config
    logic [12:0] r_max_dim;
    logic [14:0] r_max_tm;
    logic [31:0] r_pix_fmt;

    // parse state
    t_phase      r_phase, n_phase;
    t_hunt       r_hunt, n_hunt;
    logic [4:0]  r_cnt, n_cnt;
    logic [26:0] r_left, n_left;
    logic        r_prev_ff, n_prev_ff;
    logic [12:0] r_wd, n_wd;
    logic [12:0] r_ht, n_ht;
    logic        r_first, n_first;
    logic [7:0]  r_hdr [RAW_HDR_LEN];
    logic [25:0] r_area;

    // replay window
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd;
    logic [AW-1:0] r_rp, n_rp;
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_hs, n_hs;

    // result staging
    logic    r_ov, n_ov;
    t_result r_out, n_out;
    logic    r_olast, n_olast;
    logic    r_pv, n_pv;
    t_result r_pend, n_pend;

    logic                 w_proc;
    logic [7:0]           w_b;
    logic                 w_rej;
    logic                 w_jst;
    logic                 w_hdr_wr;
    logic                 w_res_v;
    t_result              w_res;
    logic                 w_more;
    logic                 w_step_end;
    logic                 w_can_push;
    logic [31:0]          w_w, w_h, w_f, w_n, w_tn;
    logic [DIM_CMP_W-1:0] w_dim_lim;
    logic [TM_CMP_W-1:0]  w_tm_lim;
    logic                 w_raw_ok;
    logic                 w_tm_ok;

    assign w_proc     = i_cmd.take_in || i_cmd.take_mem;
    assign w_b        = i_cmd.take_in ? i_in_byte : r_rd;
    assign w_can_push = !r_ov || i_out_ready;

    assign w_w  = {r_hdr[7], r_hdr[6], r_hdr[5], r_hdr[4]};
    assign w_h  = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_f  = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign w_n  = {w_b, r_hdr[18], r_hdr[17], r_hdr[16]};
    assign w_tn = {w_b, r_hdr[6], r_hdr[5], r_hdr[4]};

    assign w_dim_lim = ({1'b0, r_max_dim} < DIM_LIM_C) ? {1'b0, r_max_dim} : DIM_LIM_C;
    assign w_tm_lim  = ({2'b00, r_max_tm} < TM_LIM_C) ? {2'b00, r_max_tm} : TM_LIM_C;

    assign w_raw_ok = (w_w != 32'd0) && (w_h != 32'd0)
                   && (w_w[31:DIM_CMP_W] == '0) && (w_h[31:DIM_CMP_W] == '0)
                   && (w_w[DIM_CMP_W-1:0] <= w_dim_lim) && (w_h[DIM_CMP_W-1:0] <= w_dim_lim)
                   && (w_f == r_pix_fmt)
                   && (w_n[31:28] == 4'd0) && (w_n[27:0] == {r_area, 2'b00})
                   && (w_n <= MAX_RAW_PAYLOAD);
    assign w_tm_ok  = (w_tn[31:TM_CMP_W] == '0) && (w_tn[TM_CMP_W-1:0] <= w_tm_lim);

    always_comb begin
        n_phase   = r_phase;
        n_hunt    = r_hunt;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_prev_ff = r_prev_ff;
        n_wd      = r_wd;
        n_ht      = r_ht;
        n_first   = r_first;
        n_hs      = r_hs;
        w_rej     = 1'b0;
        w_jst     = 1'b0;
        w_hdr_wr  = 1'b0;
        w_res_v   = 1'b0;
        w_res     = '0;
        if (i_cmd.emit_d8) begin
            w_res_v          = 1'b1;
            w_res.kind       = KIND_JPEG;
            w_res.data_byte  = JPEG_SOI;
            w_res.byte_valid = 1'b1;
        end else if (w_proc) begin
            case (r_phase)
                PH_RAW_HDR, PH_TM_HDR: begin
                    w_hdr_wr = 1'b1;
                    n_cnt    = r_cnt + 5'd1;
                    if (r_phase == PH_RAW_HDR && r_cnt == 5'(RAW_HDR_LEN - 1)) begin
                        if (w_raw_ok) begin
                            n_wd    = w_w[12:0];
                            n_ht    = w_h[12:0];
                            n_left  = w_n[26:0];
                            n_phase = PH_RAW_PAY;
                            n_first = 1'b1;
                        end else begin
                            w_rej = 1'b1;
                        end
                    end else if (r_phase == PH_TM_HDR && r_cnt == 5'(TM_HDR_LEN - 1)) begin
                        if (!w_tm_ok) begin
                            w_rej = 1'b1;
                        end else if (w_tn == 32'd0) begin
                            w_res_v            = 1'b1;
                            w_res.kind         = KIND_TM;
                            w_res.packet_start = 1'b1;
                            w_res.packet_end   = 1'b1;
                            n_phase            = PH_HUNT;
                            n_cnt              = 5'd0;
                        end else begin
                            n_left  = 27'(w_tn[TM_CMP_W-1:0]);
                            n_phase = PH_TM_PAY;
                            n_first = 1'b1;
                        end
                    end
                end
                PH_RAW_PAY, PH_TM_PAY: begin
                    n_left             = r_left - 27'd1;
                    w_res_v            = 1'b1;
                    w_res.kind         = (r_phase == PH_RAW_PAY) ? KIND_RAW : KIND_TM;
                    w_res.data_byte    = w_b;
                    w_res.byte_valid   = 1'b1;
                    w_res.packet_start = r_first;
                    w_res.packet_end   = (r_left == 27'd1);
                    if (r_phase == PH_RAW_PAY) begin
                        w_res.frame_width  = r_wd;
                        w_res.frame_height = r_ht;
                    end
                    n_first = 1'b0;
                    if (r_left == 27'd1) n_phase = PH_HUNT;
                end
                PH_JPEG: begin
                    w_res_v          = 1'b1;
                    w_res.kind       = KIND_JPEG;
                    w_res.data_byte  = w_b;
                    w_res.byte_valid = 1'b1;
                    w_res.packet_end = r_prev_ff && (w_b == JPEG_EOI);
                    n_prev_ff        = (w_b == JPEG_FF);
                    if (r_prev_ff && (w_b == JPEG_EOI)) begin
                        n_phase   = PH_HUNT;
                        n_prev_ff = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (r_hunt == HP_W && w_b == CH_B) begin
                        n_hunt = HP_WB;
                    end else if (r_hunt == HP_WB && w_b == CH_F) begin
                        n_hunt = HP_WBF;
                    end else if (r_hunt == HP_WB && w_b == CH_T) begin
                        n_hunt = HP_WBT;
                    end else if (r_hunt == HP_WBF && w_b == CH_R) begin
                        n_phase = PH_RAW_HDR;
                        n_cnt   = 5'd4;
                        n_hunt  = HP_NONE;
                        n_hs    = r_rp - AW'(3);
                    end else if (r_hunt == HP_WBT && w_b == CH_M) begin
                        n_phase = PH_TM_HDR;
                        n_cnt   = 5'd4;
                        n_hunt  = HP_NONE;
                        n_hs    = r_rp - AW'(3);
                    end else if (r_hunt == HP_FF && w_b == JPEG_SOI) begin
                        w_jst              = 1'b1;
                        w_res_v            = 1'b1;
                        w_res.kind         = KIND_JPEG;
                        w_res.data_byte    = JPEG_FF;
                        w_res.byte_valid   = 1'b1;
                        w_res.packet_start = 1'b1;
                        n_phase            = PH_JPEG;
                        n_prev_ff          = 1'b0;
                        n_hunt             = HP_NONE;
                    end else if (w_b == CH_W) begin
                        n_hunt = HP_W;
                    end else if (w_b == JPEG_FF) begin
                        n_hunt = HP_FF;
                    end else begin
                        n_hunt = HP_NONE;
                    end
                end
            endcase
            if (w_rej) begin
                n_phase = PH_HUNT;
                n_hunt  = HP_NONE;
                n_cnt   = 5'd0;
            end
        end
    end

    // rejected header: rewind to the byte after its first
    always_comb begin
        n_rp = r_rp;
        n_wp = r_wp;
        if (w_proc) n_rp = w_rej ? (r_hs + AW'(1)) : (r_rp + AW'(1));
        if (i_cmd.take_in) n_wp = r_wp + AW'(1);
    end

    assign w_more = i_cmd.emit_d8 ? (r_rp != r_wp)
                  : (w_rej || (i_cmd.take_mem && ((r_rp + AW'(1)) != r_wp)));
    assign w_step_end = (w_proc || i_cmd.emit_d8) && !w_more && !w_jst;

    // one result held back so the last of an item can be flagged
    always_comb begin
        n_ov    = r_ov && !i_out_ready;
        n_out   = r_out;
        n_olast = r_olast;
        n_pv    = r_pv;
        n_pend  = r_pend;
        if (i_cmd.flush) begin
            n_ov    = 1'b1;
            n_out   = r_pend;
            n_olast = 1'b1;
            n_pv    = 1'b0;
        end else if (w_res_v) begin
            if (r_pv) begin
                n_ov    = 1'b1;
                n_out   = r_pend;
                n_olast = 1'b0;
                n_pend  = w_res;
            end else if (w_step_end) begin
                n_ov    = 1'b1;
                n_out   = w_res;
                n_olast = 1'b1;
            end else begin
                n_pend = w_res;
                n_pv   = 1'b1;
            end
        end else if (w_step_end && r_pv) begin
            n_ov    = 1'b1;
            n_out   = r_pend;
            n_olast = 1'b1;
            n_pv    = 1'b0;
        end
    end

    assign o_status.can_push   = w_can_push;
    assign o_status.jpeg_start = w_jst;
    assign o_status.more       = w_more;
    assign o_status.flush_need = w_res_v && r_pv && w_step_end;

    assign o_out_valid = r_ov;
    assign o_out_res   = r_out;
    assign o_out_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dim <= RST_MAX_DIM;
            r_max_tm  <= RST_MAX_TM;
            r_pix_fmt <= RST_PIX_FMT;
            r_phase   <= PH_HUNT;
            r_hunt    <= HP_NONE;
            r_cnt     <= 5'd0;
            r_left    <= 27'd0;
            r_prev_ff <= 1'b0;
            r_wd      <= 13'd0;
            r_ht      <= 13'd0;
            r_first   <= 1'b0;
            r_rp      <= '0;
            r_wp      <= '0;
            r_hs      <= '0;
            r_ov      <= 1'b0;
            r_pv      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_DIM: r_max_dim <= i_cfg_data[12:0];
                    CFG_MAX_TM:  r_max_tm  <= i_cfg_data[14:0];
                    CFG_PIX_FMT: r_pix_fmt <= i_cfg_data[31:0];
                    default:     r_max_dim <= r_max_dim;
                endcase
            end
            r_phase   <= n_phase;
            r_hunt    <= n_hunt;
            r_cnt     <= n_cnt;
            r_left    <= n_left;
            r_prev_ff <= n_prev_ff;
            r_wd      <= n_wd;
            r_ht      <= n_ht;
            r_first   <= n_first;
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_hs      <= n_hs;
            r_ov      <= n_ov;
            r_pv      <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_olast <= n_olast;
        r_pend  <= n_pend;
        r_area  <= {r_hdr[5][4:0], r_hdr[4]} * {r_hdr[9][4:0], r_hdr[8]};
        if (w_hdr_wr) r_hdr[r_cnt] <= w_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) r_mem[r_wp] <= i_in_byte;
        r_rd <= r_mem[r_rp];
    end

endmodule
`default_nettype wire

@@ sv/camera_stream_packet_deframer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_in_ch   in   valid/ready   in_byte
// o_out_ch  out  valid/ready   kind, data_byte, byte_valid, packet_start, packet_end,
//                              frame_width, frame_height, run_last
// A byte taken from i_in_ch is processed in the cycle it is accepted.
// A rejected header rewinds a read pointer into the replay window; each replayed byte
// is first read from the window and then processed, a JPEG start adds a step for its D8,
// and an item that ends with two results still queued adds a step to release the held one.
// Reset is synchronous: parser goes to hunting, config to defaults, output empty.
// Input is held off while the output register is full and not being taken, and while
// a replay, the D8 of a JPEG start or a held result release is in progress.
module camera_stream_packet_deframer_core #(
    parameter int HEADER_BYTES    = cspd_pkg::DEF_HEADER_BYTES,
    parameter int DIM_LIMIT       = cspd_pkg::DEF_DIM_LIMIT,
    parameter int TELEMETRY_LIMIT = cspd_pkg::DEF_TELEMETRY_LIMIT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [cspd_pkg::CFG_W-1:0] i_cfg_data,
    cspd_in_if.sink                    i_in_ch,
    cspd_out_if.source                 o_out_ch
);
    import cspd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_result w_res;
    logic    w_in_ready;
    logic    w_out_valid;
    logic    w_out_last;

    cspd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cspd_datapath #(
        .HEADER_BYTES    (HEADER_BYTES),
        .DIM_LIMIT       (DIM_LIMIT),
        .TELEMETRY_LIMIT (TELEMETRY_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_byte   (i_in_ch.in_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out_ch.ready),
        .o_out_res   (w_res),
        .o_out_last  (w_out_last)
    );

    assign i_in_ch.ready         = w_in_ready;
    assign o_out_ch.valid        = w_out_valid;
    assign o_out_ch.kind         = w_res.kind;
    assign o_out_ch.data_byte    = w_res.data_byte;
    assign o_out_ch.byte_valid   = w_res.byte_valid;
    assign o_out_ch.packet_start = w_res.packet_start;
    assign o_out_ch.packet_end   = w_res.packet_end;
    assign o_out_ch.frame_width  = w_res.frame_width;
    assign o_out_ch.frame_height = w_res.frame_height;
    assign o_out_ch.run_last     = w_out_last;

endmodule
`default_nettype wire

@@ sv/cspd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cspd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [7:0]  i_data_byte,
    input logic        i_byte_valid,
    input logic        i_packet_start,
    input logic        i_packet_end,
    input logic [12:0] i_frame_width,
    input logic [12:0] i_frame_height,
    input logic        i_run_last
);
    import cspd_pkg::*;

    a_empty_tm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_packet_start && i_packet_end && i_kind == KIND_TM)
        else $error("empty item is not a bare telemetry packet");

    a_dims_raw_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_RAW |-> i_frame_width == 13'd0 && i_frame_height == 13'd0)
        else $error("frame dimensions on non-raw item");

    a_jpeg_soi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_JPEG && i_packet_start |-> i_data_byte == JPEG_FF
            && !i_run_last && !i_packet_end)
        else $error("jpeg start item malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte) && $stable(i_kind)
            && $stable(i_run_last))
        else $error("stalled output item changed");

endmodule

bind camera_stream_packet_deframer_core cspd_checker u_cspd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_ch.valid),
    .i_out_ready    (o_out_ch.ready),
    .i_kind         (o_out_ch.kind),
    .i_data_byte    (o_out_ch.data_byte),
    .i_byte_valid   (o_out_ch.byte_valid),
    .i_packet_start (o_out_ch.packet_start),
    .i_packet_end   (o_out_ch.packet_end),
    .i_frame_width  (o_out_ch.frame_width),
    .i_frame_height (o_out_ch.frame_height),
    .i_run_last     (o_out_ch.run_last)
);
`default_nettype wire

@@ tb/cspd_deframe_checker.sv @@
`timescale 1ns / 1ps
module cspd_deframe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    cspd_in_if          in_ch,
    cspd_out_if         out_ch,
    output int          o_errors,
    output int          o_pending
);
    import cspd_pkg::*;

    typedef struct {
        t_result r;
        logic    last;
    } pkt_beat_t;

    pkt_beat_t   beat_q[$];
    pkt_beat_t   step_beats[$];
    logic [7:0]  replay_q[$];

    logic [12:0] lim_dim;
    logic [14:0] lim_tm;
    logic [31:0] want_fmt;

    t_hunt       hunt;
    t_phase      phase;
    logic [7:0]  hdr [20];
    int          hdr_cnt;
    logic [31:0] left;
    logic        saw_ff;
    logic [12:0] wid_hold;
    logic [12:0] hgt_hold;

    function automatic void push_beat(logic [1:0] k, logic [7:0] d, logic v, logic s,
                                      logic e, logic [12:0] w, logic [12:0] h);
        pkt_beat_t pb;
        if (step_beats.size() >= 20) return;
        pb.r.kind = k;
        pb.r.data_byte = d;
        pb.r.byte_valid = v;
        pb.r.packet_start = s;
        pb.r.packet_end = e;
        pb.r.frame_width = w;
        pb.r.frame_height = h;
        pb.last = 1'b0;
        step_beats.push_back(pb);
    endfunction

    function automatic logic [31:0] le32(int pos);
        return {hdr[pos + 3], hdr[pos + 2], hdr[pos + 1], hdr[pos]};
    endfunction

    function automatic void drop_header();
        for (int i = hdr_cnt - 1; i >= 1; i--) begin
            if (i < 20) replay_q.push_front(hdr[i]);
        end
        phase = PH_HUNT;
        hdr_cnt = 0;
        hunt = HP_NONE;
    endfunction

    function automatic void open_header(t_phase ph, logic [7:0] c2, logic [7:0] c3);
        hdr[0] = CH_W;
        hdr[1] = CH_B;
        hdr[2] = c2;
        hdr[3] = c3;
        hdr_cnt = 4;
        phase = ph;
        hunt = HP_NONE;
    endfunction

    function automatic void judge_raw();
        logic [31:0] w, h, f, n;
        logic [31:0] lim;
        logic [63:0] area;
        w = le32(4);
        h = le32(8);
        f = le32(12);
        n = le32(16);
        lim = (lim_dim < 4096) ? 32'(lim_dim) : 32'd4096;
        area = 64'(w) * 64'(h) * 64'd4;
        if (!(w != 0 && h != 0 && w <= lim && h <= lim && f == want_fmt &&
              area == 64'(n) && n <= MAX_RAW_PAYLOAD)) begin
            drop_header();
            return;
        end
        wid_hold = w[12:0];
        hgt_hold = h[12:0];
        left = n;
        phase = PH_RAW_PAY;
    endfunction

    function automatic void judge_tm();
        logic [31:0] n;
        logic [31:0] lim;
        n = le32(4);
        lim = (lim_tm < 16384) ? 32'(lim_tm) : 32'd16384;
        if (n > lim) begin
            drop_header();
            return;
        end
        if (n == 0) begin
            push_beat(KIND_TM, 8'h00, 1'b0, 1'b1, 1'b1, 13'd0, 13'd0);
            phase = PH_HUNT;
            hdr_cnt = 0;
            return;
        end
        left = n;
        phase = PH_TM_PAY;
    endfunction

    function automatic void scan(logic [7:0] b);
        if (hunt == HP_W && b == CH_B) hunt = HP_WB;
        else if (hunt == HP_WB && b == CH_F) hunt = HP_WBF;
        else if (hunt == HP_WB && b == CH_T) hunt = HP_WBT;
        else if (hunt == HP_WBF && b == CH_R) open_header(PH_RAW_HDR, CH_F, CH_R);
        else if (hunt == HP_WBT && b == CH_M) open_header(PH_TM_HDR, CH_T, CH_M);
        else if (hunt == HP_FF && b == JPEG_SOI) begin
            push_beat(KIND_JPEG, JPEG_FF, 1'b1, 1'b1, 1'b0, 13'd0, 13'd0);
            push_beat(KIND_JPEG, JPEG_SOI, 1'b1, 1'b0, 1'b0, 13'd0, 13'd0);
            phase = PH_JPEG;
            saw_ff = 1'b0;
            hunt = HP_NONE;
        end else begin
            hunt = (b == CH_W) ? HP_W : (b == JPEG_FF) ? HP_FF : HP_NONE;
        end
    endfunction

    function automatic void eat(logic [7:0] b);
        logic first, fin;
        case (phase)
            PH_RAW_HDR, PH_TM_HDR: begin
                if (hdr_cnt < 20) hdr[hdr_cnt] = b;
                hdr_cnt++;
                if (phase == PH_RAW_HDR && hdr_cnt >= RAW_HDR_LEN) judge_raw();
                else if (phase == PH_TM_HDR && hdr_cnt >= TM_HDR_LEN) judge_tm();
            end
            PH_RAW_PAY, PH_TM_PAY: begin
                first = hdr_cnt != 0;
                hdr_cnt = 0;
                if (left != 0) left = left - 1;
                fin = left == 0;
                if (phase == PH_RAW_PAY)
                    push_beat(KIND_RAW, b, 1'b1, first, fin, wid_hold, hgt_hold);
                else
                    push_beat(KIND_TM, b, 1'b1, first, fin, 13'd0, 13'd0);
                if (fin) phase = PH_HUNT;
            end
            PH_JPEG: begin
                fin = saw_ff && b == JPEG_EOI;
                push_beat(KIND_JPEG, b, 1'b1, 1'b0, fin, 13'd0, 13'd0);
                saw_ff = b == JPEG_FF;
                if (fin) begin
                    phase = PH_HUNT;
                    saw_ff = 1'b0;
                end
            end
            default: begin
                phase = PH_HUNT;
                scan(b);
            end
        endcase
    endfunction

    function automatic void deframe(logic [7:0] b);
        step_beats.delete();
        replay_q.delete();
        replay_q.push_back(b);
        while (replay_q.size() > 0) eat(replay_q.pop_front());
        if (step_beats.size() > 0) step_beats[$].last = 1'b1;
        foreach (step_beats[i]) beat_q.push_back(step_beats[i]);
    endfunction

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        pkt_beat_t pb;
        if (!i_rst_n) begin
            lim_dim = RST_MAX_DIM;
            lim_tm = RST_MAX_TM;
            want_fmt = RST_PIX_FMT;
            hunt = HP_NONE;
            phase = PH_HUNT;
            hdr_cnt = 0;
            left = 0;
            saw_ff = 1'b0;
            wid_hold = 0;
            hgt_hold = 0;
            beat_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_DIM: lim_dim = i_cfg_data[12:0];
                    CFG_MAX_TM:  lim_tm = i_cfg_data[14:0];
                    CFG_PIX_FMT: want_fmt = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) deframe(in_ch.in_byte);
            if (out_ch.valid && out_ch.ready) begin
                if (beat_q.size() == 0) begin
                    $error("unexpected result item, data_byte %h", out_ch.data_byte);
                    o_errors++;
                end else begin
                    pb = beat_q.pop_front();
                    if (out_ch.kind !== pb.r.kind) begin
                        $error("kind: expected %0d actual %0d", pb.r.kind, out_ch.kind);
                        o_errors++;
                    end
                    if (out_ch.data_byte !== pb.r.data_byte) begin
                        $error("data_byte: expected %h actual %h", pb.r.data_byte,
                               out_ch.data_byte);
                        o_errors++;
                    end
                    if (out_ch.byte_valid !== pb.r.byte_valid) begin
                        $error("byte_valid: expected %b actual %b", pb.r.byte_valid,
                               out_ch.byte_valid);
                        o_errors++;
                    end
                    if (out_ch.packet_start !== pb.r.packet_start) begin
                        $error("packet_start: expected %b actual %b", pb.r.packet_start,
                               out_ch.packet_start);
                        o_errors++;
                    end
                    if (out_ch.packet_end !== pb.r.packet_end) begin
                        $error("packet_end: expected %b actual %b", pb.r.packet_end,
                               out_ch.packet_end);
                        o_errors++;
                    end
                    if (out_ch.frame_width !== pb.r.frame_width) begin
                        $error("frame_width: expected %0d actual %0d", pb.r.frame_width,
                               out_ch.frame_width);
                        o_errors++;
                    end
                    if (out_ch.frame_height !== pb.r.frame_height) begin
                        $error("frame_height: expected %0d actual %0d", pb.r.frame_height,
                               out_ch.frame_height);
                        o_errors++;
                    end
                    if (out_ch.run_last !== pb.last) begin
                        $error("run_last: expected %b actual %b", pb.last, out_ch.run_last);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = beat_q.size();
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import cspd_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;
    int          cycles;
    bit          long_hold;

    logic [31:0] cur_dim;
    logic [31:0] cur_tm;
    logic [31:0] cur_fmt;
    logic [7:0]  stream[$];

    cspd_in_if  in_ch();
    cspd_out_if out_ch();

    camera_stream_packet_deframer_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in_ch   (in_ch),
        .o_out_ch  (out_ch)
    );

    cspd_deframe_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always begin
        int n;
        @(negedge i_clk);
        if (long_hold) begin
            out_ch.ready <= 1'b0;
            repeat (300) @(negedge i_clk);
            long_hold = 1'b0;
        end
        n = $urandom_range(0, 3);
        if (n != 0) begin
            out_ch.ready <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
    end

    function automatic void put32(logic [31:0] v);
        for (int i = 0; i < 4; i++) stream.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_rand(int n);
        for (int i = 0; i < n; i++) stream.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_raw(logic [31:0] w, logic [31:0] h, logic [31:0] f,
                                    logic [31:0] len, int npay);
        stream.push_back(CH_W);
        stream.push_back(CH_B);
        stream.push_back(CH_F);
        stream.push_back(CH_R);
        put32(w);
        put32(h);
        put32(f);
        put32(len);
        put_rand(npay);
    endfunction

    function automatic void put_tm(logic [31:0] len, int npay);
        stream.push_back(CH_W);
        stream.push_back(CH_B);
        stream.push_back(CH_T);
        stream.push_back(CH_M);
        put32(len);
        put_rand(npay);
    endfunction

    function automatic void put_jpeg(int nbody);
        stream.push_back(JPEG_FF);
        stream.push_back(JPEG_SOI);
        for (int i = 0; i < nbody; i++)
            stream.push_back(($urandom_range(0, 3) == 0) ? JPEG_FF
                                                         : 8'($urandom_range(0, 255)));
        stream.push_back(JPEG_FF);
        stream.push_back(JPEG_EOI);
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain_stream(output int n);
        n = stream.size();
        while (stream.size() > 0) send_byte(stream.pop_front());
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_cfg(logic [31:0] d, logic [31:0] t, logic [31:0] f);
        settle();
        write_reg(CFG_MAX_DIM, d);
        write_reg(CFG_MAX_TM, t);
        write_reg(CFG_PIX_FMT, f);
        cur_dim = d & 32'h1FFF;
        cur_tm = t & 32'h7FFF;
        cur_fmt = f;
    endtask

    task automatic random_phase(int nbytes, bit with_hold);
        int sent, n, sel, w, h, edim, etm;
        sent = 0;
        edim = (cur_dim < 4096) ? cur_dim : 4096;
        etm = (cur_tm < 16384) ? cur_tm : 16384;
        if (with_hold) begin
            long_hold = 1'b1;
            put_tm((etm < 40) ? etm : 40, (etm < 40) ? etm : 40);
            drain_stream(n);
            sent += n;
        end
        while (sent < nbytes) begin
            sel = $urandom_range(0, 9);
            w = $urandom_range(1, (edim < 3) ? ((edim < 1) ? 1 : edim) : 3);
            h = $urandom_range(1, (edim < 3) ? ((edim < 1) ? 1 : edim) : 3);
            case (sel)
                0, 1, 2: put_raw(w, h, cur_fmt, w * h * 4, w * h * 4);
                3: begin
                    case ($urandom_range(0, 3))
                        0: put_raw(w, h, cur_fmt ^ 32'h1, w * h * 4, 4);
                        1: put_raw(edim + 1, h, cur_fmt, (edim + 1) * h * 4, 4);
                        2: put_raw(w, h, cur_fmt, w * h * 4 + 1, 4);
                        default: put_raw(0, h, cur_fmt, 0, 4);
                    endcase
                end
                4, 5: begin
                    n = $urandom_range(0, (etm < 12) ? etm : 12);
                    put_tm(n, n);
                end
                6: put_tm(etm + $urandom_range(1, 100), 3);
                7, 8: put_jpeg($urandom_range(0, 10));
                default: begin
                    if ($urandom_range(0, 1)) begin
                        stream.push_back(CH_W);
                        stream.push_back(CH_B);
                    end
                    put_rand($urandom_range(1, 6));
                end
            endcase
            drain_stream(n);
            sent += n;
        end
    endtask

    initial begin
        int n;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        out_ch.ready = 1'b0;
        long_hold = 1'b0;
        cur_dim = RST_MAX_DIM;
        cur_tm = RST_MAX_TM;
        cur_fmt = RST_PIX_FMT;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset settings
        put_raw(1, 1, 1, 4, 4);
        put_tm(0, 0);
        put_tm(3, 3);
        put_jpeg(3);
        stream.push_back(JPEG_FF);
        stream.push_back(JPEG_SOI);
        stream.push_back(JPEG_EOI);
        stream.push_back(JPEG_FF);
        stream.push_back(JPEG_EOI);
        // header holding a telemetry marker, rejected and rescanned
        put_raw(32'h4D54_4257, 1, 1, 4, 0);
        put32(0);
        put_raw(2, 2, 2, 16, 2);
        put_raw(0, 1, 1, 0, 1);
        put_raw(4097, 1, 1, 4097 * 4, 1);
        put_raw(2, 2, 1, 15, 1);
        put_tm(16384 + 1, 2);
        put_tm(32'hFFFF_FFFF, 2);
        stream.push_back(8'h00);
        stream.push_back(8'hFF);
        drain_stream(n);

        set_cfg(32'd1, 32'd0, 32'd0);
        put_tm(1, 1);
        put_raw(2, 1, 0, 8, 2);
        drain_stream(n);
        random_phase(30, 1'b0);

        set_cfg(32'd8191, 32'd32767, 32'hFFFF_FFFF);
        random_phase(90, 1'b1);

        set_cfg(32'd4096, 32'd16384, $urandom);
        random_phase(30, 1'b0);

        set_cfg(32'd3, 32'd5, 32'd1);
        random_phase(25, 1'b0);

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);
        if (pending != 0) $error("result items missing: %0d", pending);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/cspd_pkg.sv
sv/cspd_in_if.sv
sv/cspd_out_if.sv
sv/cspd_ctrl.sv
sv/cspd_datapath.sv
sv/camera_stream_packet_deframer_core.sv
sv/cspd_checker.sv
tb/cspd_deframe_checker.sv
tb/tb_top.sv
